// ----- rtl/core/mandelbrot_pixel_color_core_assert.svh -----
// Assertion macros for the escape-time pixel core.
`ifndef MANDELBROT_PIXEL_COLOR_CORE_ASSERT_SVH
`define MANDELBROT_PIXEL_COLOR_CORE_ASSERT_SVH
// Implication checked at each posedge of clk outside reset.
`define MPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define MPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/mpc_pkg.sv -----
// Types, constants and saturation function for the escape-time core.
`default_nettype none
package mpc_pkg;
  localparam int MAX_ITER_DEF = 32;
  localparam int CW = 32;
  localparam logic [1:0] REG_ORIGIN_RE = 2'd0;
  localparam logic [1:0] REG_ORIGIN_IM = 2'd1;
  localparam logic [1:0] REG_STEP_RE   = 2'd2;
  localparam logic [1:0] REG_STEP_IM   = 2'd3;
  localparam logic signed [CW-1:0] RST_ORIGIN_RE = -32'sd536870912;
  localparam logic signed [CW-1:0] RST_ORIGIN_IM = -32'sd322122547;
  localparam logic signed [CW-1:0] RST_STEP_RE   = 32'sd98426;
  localparam logic signed [CW-1:0] RST_STEP_IM   = 32'sd99115;

  typedef struct packed {
    logic [15:0] pixel_col;
    logic [15:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [5:0] iter_count;
  } out_word_t;

  // Saturate a 38-bit signed value to 32 bits.
  function automatic logic signed [CW-1:0] sat38(input logic signed [37:0] x);
    logic signed [CW-1:0] r;
    if (x > 38'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -38'sd2147483648) r = 32'sh80000000;
    else r = x[CW-1:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/mpc_iter.sv -----
// One Mandelbrot iteration stage, split in a multiply half and an update half.
`default_nettype none
module mpc_iter
  import mpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic              in_done,
  input  wire logic [8:0]        in_n,
  input  wire logic signed [31:0] in_zr,
  input  wire logic signed [31:0] in_zi,
  input  wire logic signed [31:0] in_cr,
  input  wire logic signed [31:0] in_ci,
  input  wire logic [15:0]       in_tag,
  output logic                   out_vld,
  output logic                   out_done,
  output logic [8:0]             out_n,
  output logic signed [31:0]     out_zr,
  output logic signed [31:0]     out_zi,
  output logic signed [31:0]     out_cr,
  output logic signed [31:0]     out_ci,
  output logic [15:0]            out_tag
);
  // First half: products registered.
  logic signed [63:0] rr_r, ii_r, ri_r;
  logic signed [31:0] cr_r, ci_r;
  logic               vld_r, done_r;
  logic [8:0]         n_r;
  logic [15:0]        tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      rr_r  <= in_zr * in_zr;
      ii_r  <= in_zi * in_zi;
      ri_r  <= in_zr * in_zi;
      cr_r  <= in_cr;
      ci_r  <= in_ci;
      done_r <= in_done;
      n_r   <= in_n;
      tag_r <= in_tag;
    end
  end

  // Second half: escape test and update.
  logic [64:0]        mag;
  logic               esc;
  logic signed [64:0] dif;
  logic signed [37:0] nre, nim;
  logic signed [31:0] zr_nxt, zi_nxt;

  always_comb begin
    mag = {1'b0, rr_r} + {1'b0, ii_r};
    esc = mag[63:0] > (64'd4 << 56);
    dif = 65'(rr_r) - 65'(ii_r);
    nre = 38'(dif >>> 28) + 38'(cr_r);
    nim = 38'(ri_r >>> 27) + 38'(ci_r);
    zr_nxt = sat38(nre);
    zi_nxt = sat38(nim);
  end

  logic vld2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld_r;
    end
    if (en) begin
      out_cr  <= cr_r;
      out_ci  <= ci_r;
      out_tag <= tag_r;
      if (done_r || esc) begin
        out_done <= 1'b1;
        out_n    <= n_r;
        out_zr   <= 32'sd0;
        out_zi   <= 32'sd0;
      end else begin
        out_done <= 1'b0;
        out_n    <= n_r + 9'd1;
        out_zr   <= zr_nxt;
        out_zi   <= zi_nxt;
      end
    end
  end
  assign out_vld = vld2_r;
endmodule
`default_nettype wire

// ----- rtl/core/mpc_color.sv -----
// Two-stage color mapping from the final iteration count.
`default_nettype none
module mpc_color
  import mpc_pkg::*;
#(
  parameter int MAX_ITER = MAX_ITER_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       en,
  input  wire logic       in_vld,
  input  wire logic [8:0] in_n,
  output logic            out_vld,
  output out_word_t       out_word
);
  localparam int M2 = MAX_ITER * MAX_ITER;

  // Stage one: the shades come from a constant table indexed by the count.
  logic [7:0] qr_nxt, qg_nxt, qb_nxt;
  always_comb begin
    qr_nxt = 8'd0;
    qg_nxt = 8'd0;
    qb_nxt = 8'd0;
    for (int k = 0; k < MAX_ITER; k++) begin
      if (in_n == 9'(k)) begin
        qr_nxt = 8'((k * k * 255) / M2);
        qg_nxt = 8'((k * 128) / MAX_ITER);
        qb_nxt = 8'((k * 255) / MAX_ITER);
      end
    end
  end

  logic [7:0] qr_r, qg_r, qb_r;
  logic [8:0] n_r;
  logic       v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= in_vld;
    if (en) begin
      qr_r <= qr_nxt;
      qg_r <= qg_nxt;
      qb_r <= qb_nxt;
      n_r  <= in_n;
    end
  end

  // Stage two: pick black, the small-count color or the table shades.
  logic vo_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= v_r;
    if (en) begin
      out_word.iter_count <= n_r[5:0];
      if (32'(n_r) >= 32'(MAX_ITER)) begin
        out_word.red <= 8'd0; out_word.green <= 8'd0; out_word.blue <= 8'd0;
      end else if (32'(n_r) * 32'd10 < 32'(MAX_ITER)) begin
        out_word.red <= 8'd2; out_word.green <= 8'd12; out_word.blue <= 8'd25;
      end else begin
        out_word.red <= qr_r; out_word.green <= qg_r; out_word.blue <= qb_r;
      end
    end
  end
  assign out_vld = vo_r;
endmodule
`default_nettype wire

// ----- rtl/core/mandelbrot_pixel_color_core.sv -----
// Pipelined Mandelbrot escape-time pixel core: mapping, iteration stages, color.
// Registered steps: products then saturated sum for the point mapping, a multiply
// half and an update half per iteration stage, a table and a select stage for color.
// Throughput: one pixel word per cycle; the pipe freezes when out_valid && !out_ready.
// Reset clears every valid bit and loads the coordinate registers with the
// default view; the pipeline holds no words after reset.
`default_nettype none
`include "mandelbrot_pixel_color_core_assert.svh"
module mandelbrot_pixel_color_core
  import mpc_pkg::*;
#(
  parameter int MAX_ITER = MAX_ITER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  // Configuration registers.
  logic signed [31:0] ore_r, oim_r, sre_r, sim_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ore_r <= RST_ORIGIN_RE; oim_r <= RST_ORIGIN_IM;
      sre_r <= RST_STEP_RE;   sim_r <= RST_STEP_IM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_RE: ore_r <= cfg_data;
        REG_ORIGIN_IM: oim_r <= cfg_data;
        REG_STEP_RE:   sre_r <= cfg_data;
        REG_STEP_IM:   sim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipe advances when the output register is free or drained.
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Mapping: products, then sum and saturation.
  logic signed [48:0] pr_r, pi_r;
  logic               mv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else if (en) mv_r <= in_valid;
    if (en) begin
      pr_r <= $signed({1'b0, in_data.pixel_col}) * sre_r;
      pi_r <= $signed({1'b0, in_data.pixel_row}) * sim_r;
    end
  end
  logic signed [49:0] sr, si;
  assign sr = 50'(pr_r) + 50'(ore_r);
  assign si = 50'(pi_r) + 50'(oim_r);
  function automatic logic signed [31:0] sat50(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -50'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction
  logic signed [31:0] cr_r, ci_r;
  logic               cv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) cv_r <= 1'b0;
    else if (en) cv_r <= mv_r;
    if (en) begin
      cr_r <= sat50(sr);
      ci_r <= sat50(si);
    end
  end

  // Iteration chain.
  logic               v  [MAX_ITER+1];
  logic               d  [MAX_ITER+1];
  logic [8:0]         n  [MAX_ITER+1];
  logic signed [31:0] zr [MAX_ITER+1];
  logic signed [31:0] zi [MAX_ITER+1];
  logic signed [31:0] cr [MAX_ITER+1];
  logic signed [31:0] ci [MAX_ITER+1];
  logic [15:0]        tg [MAX_ITER+1];
  assign v[0] = cv_r; assign d[0] = 1'b0; assign n[0] = 9'd0;
  assign zr[0] = 32'sd0; assign zi[0] = 32'sd0;
  assign cr[0] = cr_r; assign ci[0] = ci_r; assign tg[0] = 16'd0;

  for (genvar g = 0; g < MAX_ITER; g++) begin : g_it
    mpc_iter u_it (
      .clk, .rst_n, .en,
      .in_vld(v[g]), .in_done(d[g]), .in_n(n[g]), .in_zr(zr[g]), .in_zi(zi[g]),
      .in_cr(cr[g]), .in_ci(ci[g]), .in_tag(tg[g]),
      .out_vld(v[g+1]), .out_done(d[g+1]), .out_n(n[g+1]), .out_zr(zr[g+1]),
      .out_zi(zi[g+1]), .out_cr(cr[g+1]), .out_ci(ci[g+1]), .out_tag(tg[g+1])
    );
  end

  // Color mapping and output register.
  mpc_color #(.MAX_ITER(MAX_ITER)) u_col (
    .clk, .rst_n, .en,
    .in_vld(v[MAX_ITER]), .in_n(n[MAX_ITER]),
    .out_vld(out_valid), .out_word(out_data)
  );

  // Checks.
  `MPC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed during stall")
  `MPC_ASSERT_IMP(a_ready_free, !out_valid, in_ready, "pipe not ready while output empty")
  `MPC_ASSERT_IMP(a_count_range, out_valid, 32'(out_data.iter_count) <= MAX_ITER || MAX_ITER > 63, "iteration count above limit")
endmodule
`default_nettype wire
